@@ rtl/lfus_pkg.sv @@
// shared types and constants of the length-framed utf-8 sanitiser
package lfus_pkg;

    localparam int HDR_BITS    = 32;
    localparam int MAX_RESULTS = 5;
    localparam int RES_CNT_W   = 3;

    localparam logic [HDR_BITS-1:0] MAX_TOTAL_RESET = 32'd10485760;

    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_TAB   = 8'h09;
    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD4_HI    = 8'hF7;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;

    typedef enum logic [1:0] {
        KIND_TEXT    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_REJECT  = 2'd2,
        KIND_DONE    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_TEXT    = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
    } res_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]   count;
        res_t [MAX_RESULTS-1:0] res;
    } batch_t;

endpackage

@@ rtl/lfus_byte_if.sv @@
// input byte channel
interface lfus_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/lfus_result_if.sv @@
// result channel
interface lfus_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last_of_run;

    modport source (output valid, output out_byte, output kind, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input kind, input last_of_run, output ready);
endinterface

@@ rtl/lfus_core.sv @@
// frame parser and loose utf-8 filter, one input beat per cycle while accept is high
module lfus_core #(
    parameter int SIZE_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [7:0]                         rx_byte,
    input  logic                               cfg_we,
    input  logic [lfus_pkg::HDR_BITS-1:0]      cfg_wdata,
    output lfus_pkg::batch_t                   batch
);

    localparam int CW = SIZE_BITS + 1;

    lfus_pkg::phase_t               phase_reg, phase_next;
    logic [2:0]                     header_count_reg, header_count_next;
    logic [lfus_pkg::HDR_BITS-1:0]  total_reg, total_next;
    logic [lfus_pkg::HDR_BITS-1:0]  text_reg, text_next;
    logic [SIZE_BITS-1:0]           body_reg, body_next;
    logic [2:0][7:0]                held_reg, held_next;
    logic [1:0]                     held_count_reg, held_count_next;
    logic [2:0]                     seq_len_reg, seq_len_next;
    logic [lfus_pkg::HDR_BITS-1:0]  max_total_reg;

    logic [CW-1:0] body_inc;
    logic [CW-1:0] text_ext;
    logic [CW-1:0] total_ext;
    logic [2:0]    lead_len;
    logic          room;
    logic          is_cont;
    logic          printable;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        if (b >= lfus_pkg::LEAD2_LO && b <= lfus_pkg::LEAD2_HI)
        begin
            n = 3'd2;
        end
        else if (b >= lfus_pkg::LEAD3_LO && b <= lfus_pkg::LEAD3_HI)
        begin
            n = 3'd3;
        end
        else if (b >= lfus_pkg::LEAD4_LO && b <= lfus_pkg::LEAD4_HI)
        begin
            n = 3'd4;
        end
        return n;
    endfunction

    assign body_inc  = CW'(body_reg) + CW'(1);
    assign text_ext  = {1'b0, text_reg[SIZE_BITS-1:0]};
    assign total_ext = {1'b0, total_reg[SIZE_BITS-1:0]};
    assign lead_len  = lead_length(rx_byte);
    // lead is kept only when the rest of its sequence still fits in the text
    assign room      = (CW'(body_reg) + CW'(lead_len)) <= text_ext;
    assign is_cont   = (rx_byte >= lfus_pkg::CONT_LO) && (rx_byte <= lfus_pkg::CONT_HI);
    assign printable = (rx_byte <= lfus_pkg::ASCII_MAX) &&
                       ((rx_byte >= lfus_pkg::ASCII_SPACE) || (rx_byte == lfus_pkg::ASCII_TAB) ||
                        (rx_byte == lfus_pkg::ASCII_LF) || (rx_byte == lfus_pkg::ASCII_CR));

    always_comb
    begin
        logic rescan;
        logic reject;
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        total_next        = total_reg;
        text_next         = text_reg;
        body_next         = body_reg;
        held_next         = held_reg;
        held_count_next   = held_count_reg;
        seq_len_next      = seq_len_reg;
        batch             = '0;
        rescan            = 1'b0;
        reject            = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                lfus_pkg::PH_HEADER:
                begin
                    if (header_count_reg == 3'd0)
                    begin
                        total_next = '0;
                        text_next  = '0;
                    end
                    if (!header_count_reg[2])
                    begin
                        total_next[{header_count_reg[1:0], 3'b000} +: 8] = rx_byte;
                    end
                    else
                    begin
                        text_next[{header_count_reg[1:0], 3'b000} +: 8] = rx_byte;
                    end
                    header_count_next = header_count_reg + 3'd1;
                    if (header_count_reg == 3'd7)
                    begin
                        reject = (text_next == '0) || (text_next > total_next) ||
                                 (total_next > max_total_reg) ||
                                 ((total_next >> SIZE_BITS) != '0);
                        if (reject)
                        begin
                            batch.count  = 3'd1;
                            batch.res[0] = '{data: 8'h00, kind: lfus_pkg::KIND_REJECT};
                        end
                        else
                        begin
                            phase_next      = lfus_pkg::PH_TEXT;
                            body_next       = '0;
                            held_count_next = 2'd0;
                            seq_len_next    = 3'd0;
                        end
                    end
                end
                lfus_pkg::PH_TEXT:
                begin
                    rescan = (held_count_reg == 2'd0);
                    if (held_count_reg != 2'd0)
                    begin
                        if (is_cont)
                        begin
                            if (({1'b0, held_count_reg} + 3'd1) >= seq_len_reg)
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    if (i < int'(held_count_reg))
                                    begin
                                        batch.res[i] = '{data: held_reg[i],
                                                         kind: lfus_pkg::KIND_TEXT};
                                    end
                                end
                                batch.res[{1'b0, held_count_reg}] =
                                    '{data: rx_byte, kind: lfus_pkg::KIND_TEXT};
                                batch.count     = {1'b0, held_count_reg} + 3'd1;
                                held_count_next = 2'd0;
                                seq_len_next    = 3'd0;
                            end
                            else
                            begin
                                held_next[held_count_reg] = rx_byte;
                                held_count_next           = held_count_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            // broken sequence: drop what is held and look at this byte afresh
                            held_count_next = 2'd0;
                            seq_len_next    = 3'd0;
                            rescan          = 1'b1;
                        end
                    end
                    if (rescan)
                    begin
                        if (!rx_byte[7])
                        begin
                            if (printable)
                            begin
                                batch.count  = 3'd1;
                                batch.res[0] = '{data: rx_byte, kind: lfus_pkg::KIND_TEXT};
                            end
                        end
                        else if (lead_len != 3'd0 && room)
                        begin
                            held_next[0]    = rx_byte;
                            held_count_next = 2'd1;
                            seq_len_next    = lead_len;
                        end
                    end
                    body_next = body_inc[SIZE_BITS-1:0];
                    if (body_inc >= text_ext)
                    begin
                        held_count_next = 2'd0;
                        seq_len_next    = 3'd0;
                        if (body_inc >= total_ext)
                        begin
                            batch.res[batch.count] = '{data: 8'h00, kind: lfus_pkg::KIND_DONE};
                            batch.count            = batch.count + 3'd1;
                            phase_next             = lfus_pkg::PH_HEADER;
                        end
                        else
                        begin
                            phase_next = lfus_pkg::PH_PAYLOAD;
                        end
                    end
                end
                lfus_pkg::PH_PAYLOAD:
                begin
                    batch.count  = 3'd1;
                    batch.res[0] = '{data: rx_byte, kind: lfus_pkg::KIND_PAYLOAD};
                    body_next    = body_inc[SIZE_BITS-1:0];
                    if (body_inc >= total_ext)
                    begin
                        batch.count  = 3'd2;
                        batch.res[1] = '{data: 8'h00, kind: lfus_pkg::KIND_DONE};
                        phase_next   = lfus_pkg::PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = lfus_pkg::PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= lfus_pkg::PH_HEADER;
            header_count_reg <= 3'd0;
            total_reg        <= '0;
            text_reg         <= '0;
            body_reg         <= '0;
            held_reg         <= '0;
            held_count_reg   <= 2'd0;
            seq_len_reg      <= 3'd0;
            max_total_reg    <= lfus_pkg::MAX_TOTAL_RESET;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            total_reg        <= total_next;
            text_reg         <= text_next;
            body_reg         <= body_next;
            held_reg         <= held_next;
            held_count_reg   <= held_count_next;
            seq_len_reg      <= seq_len_next;
            if (cfg_we)
            begin
                max_total_reg <= cfg_wdata;
            end
        end
    end

    a_held_only_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd0 |-> phase_reg == lfus_pkg::PH_TEXT)
        else $error("bytes held outside the text part");

    a_held_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd0 |-> {1'b0, held_count_reg} < seq_len_reg)
        else $error("held bytes reach the sequence length");

    a_body_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != lfus_pkg::PH_HEADER |-> CW'(body_reg) < total_ext)
        else $error("body count ran past the frame");

endmodule

@@ rtl/lfus_outq.sv @@
// result buffer: takes all results of one beat, drains them one per cycle while out_ready is high
module lfus_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  lfus_pkg::batch_t batch,
    input  logic             out_ready,
    output logic             out_valid,
    output lfus_pkg::res_t   head,
    output logic             out_last,
    output logic             in_ready
);

    lfus_pkg::res_t [lfus_pkg::MAX_RESULTS-1:0] res_reg, res_next;
    logic [lfus_pkg::RES_CNT_W-1:0]             cnt_reg, cnt_next;
    logic                                       pop;

    assign out_valid = (cnt_reg != '0);
    assign head      = res_reg[0];
    assign out_last  = (cnt_reg == lfus_pkg::RES_CNT_W'(1));
    assign pop       = out_valid && out_ready;
    // a new beat may enter once the last waiting result leaves
    assign in_ready  = (cnt_reg == '0) || (out_last && out_ready);

    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            res_next = batch.res;
            cnt_next = batch.count;
        end
        else if (pop)
        begin
            for (int i = 0; i < lfus_pkg::MAX_RESULTS - 1; i++)
            begin
                res_next[i] = res_reg[i+1];
            end
            cnt_next = cnt_reg - lfus_pkg::RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= lfus_pkg::RES_CNT_W'(lfus_pkg::MAX_RESULTS))
        else $error("result count out of range");

    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !load |=> cnt_reg == $past(cnt_reg) - lfus_pkg::RES_CNT_W'(1))
        else $error("result count did not step down");

    a_silent_beat: assert property (@(posedge clk) disable iff (!rst_n)
        load && batch.count == '0 |=> !out_valid)
        else $error("result shown for a silent beat");

endmodule

@@ rtl/length_framed_utf8_sanitizer.sv @@
// length-framed utf-8 sanitiser top level
// latency: a result appears the cycle after its input beat is taken
// throughput: one input beat per cycle while each beat gives at most one result and tx.ready is high
// a beat giving more than one result (up to 5) holds the input until the last of its results leaves the result buffer
// reset: rst_n async active low; parser returns to header phase, buffer empties,
// max_total_size reloads 10485760
module length_framed_utf8_sanitizer #(
    parameter int SIZE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    lfus_byte_if.sink                     rx,
    lfus_result_if.source                 tx,
    input  logic                          cfg_we,
    input  logic [lfus_pkg::HDR_BITS-1:0] cfg_wdata
);

    lfus_pkg::batch_t batch;
    lfus_pkg::res_t   head;
    logic             accept;
    logic             in_ready;

    assign rx.ready = in_ready;
    assign accept   = rx.valid && in_ready;

    lfus_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx.rx_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .batch     (batch)
    );

    lfus_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .batch     (batch),
        .out_ready (tx.ready),
        .out_valid (tx.valid),
        .head      (head),
        .out_last  (tx.last_of_run),
        .in_ready  (in_ready)
    );

    assign tx.out_byte = head.data;
    assign tx.kind     = head.kind;

endmodule
